// File: design/indexed_min_heap_decrease_key_top_assert.svh
// Assertion macros for the indexed min-heap block.
// Included by the top level; depends on nothing else.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_TOP_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while the active-low reset is low.
`define HMDK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmdk assertion failed");

// Next-cycle implication, disabled while the active-low reset is low.
`define HMDK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmdk assertion failed");

`endif

// File: design/hmdk_pkg.sv
// Package for the indexed min-heap: command and response beat types and codes.
// Used by the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hmdk_pkg;

    localparam int VW           = 10;
    localparam int VERTEX_COUNT = 1024;

    localparam logic [2:0] K_INSERT   = 3'd0;
    localparam logic [2:0] K_DECREASE = 3'd1;
    localparam logic [2:0] K_EXTRACT  = 3'd2;
    localparam logic [2:0] K_READ     = 3'd3;
    localparam logic [2:0] K_CLEAR    = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_EMPTY       = 3'd2;
    localparam logic [2:0] ST_ABSENT      = 3'd3;
    localparam logic [2:0] ST_PRESENT     = 3'd4;
    localparam logic [2:0] ST_NOT_SMALLER = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [VW-1:0]      vertex;
        logic signed [31:0] key;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic [VW-1:0]      out_vertex;
        logic signed [31:0] out_key;
        logic               is_empty;
        logic [10:0]        entry_count;
    } t_rsp;

endpackage
`default_nettype wire

// File: design/indexed_min_heap_decrease_key_top.sv
// Top level of the indexed min-heap: sequencer, heap and position memories.
// Depends on hmdk_pkg, hmdk_ram, hmdk_keycmp and the assertion macro header.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Each command gives exactly one response beat, shown on o_rsp for one cycle
// with o_strobe high; the receiver cannot hold it off.
// After reset the block clears all 1024 entries of the position map and keeps
// busy high meanwhile; the heap is then empty.
// Presence of a vertex is found by reading its position and checking that the
// slot lies below the entry count and holds that vertex, so clear takes one step.
// Every command reads the position map, then a heap slot. Clear, unused kinds
// and extract on an empty heap answer after the position read; read key and a
// failed insert or decrease answer after the slot read. Insert and decrease key
// then sift up; extract moves the last entry to the root and sifts down.
// Each level of a sift up needs one read of the heap memory's single read port
// and one compare in the shared comparator; going down it needs two reads and
// up to two compares.
// One command is in flight at a time; busy falls in the cycle of the strobe.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_decrease_key_top #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire hmdk_pkg::t_cmd i_cmd,
    output logic               busy,
    output logic               o_strobe,
    output hmdk_pkg::t_rsp     o_rsp
);
    import hmdk_pkg::*;

    `include "indexed_min_heap_decrease_key_top_assert.svh"

    localparam int KW  = KEY_WIDTH;
    localparam int SW  = $clog2(CAPACITY);
    localparam int SZW = $clog2(CAPACITY + 1);
    localparam int EW  = KW + VW;

    typedef enum logic [11:0] {
        S_CLR  = 12'b000000000001,
        S_IDLE = 12'b000000000010,
        S_CHK  = 12'b000000000100,
        S_VER  = 12'b000000001000,
        S_EX2  = 12'b000000010000,
        S_UP0  = 12'b000000100000,
        S_UP1  = 12'b000001000000,
        S_DN0  = 12'b000010000000,
        S_DN1  = 12'b000100000000,
        S_DN2  = 12'b001000000000,
        S_DN3  = 12'b010000000000,
        S_SPR  = 12'b100000000000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_kind, n_kind;
    logic [VW-1:0]    r_vtx, n_vtx;
    logic [KW-1:0]    r_key, n_key;
    logic [SW-1:0]    r_pos, n_pos;
    logic [SW-1:0]    r_p, n_p;
    logic [SW-1:0]    r_bidx, n_bidx;
    logic [EW-1:0]    r_best, n_best;
    logic [SZW-1:0]   r_size, n_size;
    logic             r_strobe, n_strobe;
    logic [2:0]       r_status, n_status;
    logic [VW-1:0]    r_ovtx, n_ovtx;
    logic [KW-1:0]    r_okey, n_okey;
    logic [VW-1:0]    r_clr, n_clr;

    logic             h_we;
    logic [SW-1:0]    h_waddr, h_raddr;
    logic [EW-1:0]    h_wdata, h_rdata;
    logic             p_we;
    logic [VW-1:0]    p_waddr;
    logic [SW-1:0]    p_wdata, p_rdata;

    logic [KW-1:0]    cmp_a, cmp_b;
    logic             gt;
    logic [KW-1:0]    hq_key;
    logic [VW-1:0]    hq_vtx;
    logic             present;
    logic [63:0]      in_ext;
    logic [SW:0]      c_idx, rc_idx;
    logic             c_in, rc_in;
    logic [SW-1:0]    parent;
    logic [SZW-1:0]   size_m1;
    logic             accept;

    hmdk_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    hmdk_ram #(.WIDTH(SW), .DEPTH(VERTEX_COUNT)) u_pos (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (i_cmd.vertex),
        .o_rdata (p_rdata)
    );

    hmdk_keycmp #(.KEY_WIDTH(KW)) u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (gt)
    );

    assign accept  = start && (r_state == S_IDLE);
    assign in_ext  = {32'd0, i_cmd.key};
    assign hq_key  = h_rdata[EW-1:VW];
    assign hq_vtx  = h_rdata[VW-1:0];
    assign present = (SZW'(r_pos) < r_size) && (hq_vtx == r_vtx);
    assign c_idx   = {r_p, 1'b1};
    assign rc_idx  = {r_p, 1'b0} + (SW+1)'(2);
    assign c_in    = (SW+2)'(c_idx) < (SW+2)'(r_size);
    assign rc_in   = (SW+2)'(rc_idx) < (SW+2)'(r_size);
    assign parent  = (r_p - SW'(1)) >> 1;
    assign size_m1 = r_size - SZW'(1);

    always_comb begin
        cmp_a = r_key;
        cmp_b = hq_key;
        case (r_state)
            S_VER: begin
                cmp_a = hq_key;
                cmp_b = r_key;
            end
            S_UP1: begin
                cmp_a = hq_key;
                cmp_b = r_key;
            end
            S_DN2: begin
                cmp_a = r_best[EW-1:VW];
                cmp_b = hq_key;
            end
            S_DN3: begin
                cmp_a = r_key;
                cmp_b = r_best[EW-1:VW];
            end
            default: begin
                cmp_a = r_key;
                cmp_b = hq_key;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_vtx    = r_vtx;
        n_key    = r_key;
        n_pos    = r_pos;
        n_p      = r_p;
        n_bidx   = r_bidx;
        n_best   = r_best;
        n_size   = r_size;
        n_strobe = 1'b0;
        n_status = r_status;
        n_ovtx   = r_ovtx;
        n_okey   = r_okey;
        n_clr    = r_clr;
        h_we     = 1'b0;
        h_waddr  = r_p;
        h_wdata  = {r_key, r_vtx};
        h_raddr  = '0;
        p_we     = 1'b0;
        p_waddr  = r_vtx;
        p_wdata  = r_p;
        case (r_state)
            S_CLR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = '0;
                n_clr   = r_clr + VW'(1);
                if (r_clr == VW'(VERTEX_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                h_raddr = '0;
                if (start) begin
                    n_kind   = i_cmd.kind;
                    n_vtx    = i_cmd.vertex;
                    n_key    = in_ext[KW-1:0];
                    n_status = ST_OK;
                    n_ovtx   = i_cmd.vertex;
                    n_okey   = '0;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_pos   = p_rdata;
                h_raddr = p_rdata;
                n_state = S_VER;
                case (r_kind)
                    K_INSERT, K_DECREASE, K_READ: begin
                        n_state = S_VER;
                    end
                    K_EXTRACT: begin
                        h_raddr = size_m1[SW-1:0];
                        if (r_size == '0) begin
                            n_status = ST_EMPTY;
                            n_ovtx   = '0;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_ovtx  = hq_vtx;
                            n_okey  = hq_key;
                            n_state = S_EX2;
                        end
                    end
                    K_CLEAR: begin
                        n_size   = '0;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_VER: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                case (r_kind)
                    K_INSERT: begin
                        if (present) begin
                            n_status = ST_PRESENT;
                        end else if (r_size == SZW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_p      = r_size[SW-1:0];
                            n_size   = r_size + SZW'(1);
                            n_strobe = 1'b0;
                            n_state  = S_UP0;
                        end
                    end
                    K_DECREASE: begin
                        if (!present) begin
                            n_status = ST_ABSENT;
                        end else if (!gt) begin
                            n_status = ST_NOT_SMALLER;
                        end else begin
                            n_p      = r_pos;
                            n_strobe = 1'b0;
                            n_state  = S_UP0;
                        end
                    end
                    default: begin
                        if (!present) begin
                            n_status = ST_ABSENT;
                        end else begin
                            n_okey = hq_key;
                        end
                    end
                endcase
            end
            S_EX2: begin
                n_key  = hq_key;
                n_vtx  = hq_vtx;
                n_size = size_m1;
                n_p    = '0;
                if (size_m1 == '0) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DN0;
                end
            end
            S_UP0: begin
                h_raddr = parent;
                n_bidx  = parent;
                if (r_p == '0) begin
                    h_we     = 1'b1;
                    p_we     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_UP1;
                end
            end
            S_UP1: begin
                if (gt) begin
                    h_we    = 1'b1;
                    h_wdata = h_rdata;
                    p_we    = 1'b1;
                    p_waddr = hq_vtx;
                    n_p     = r_bidx;
                    n_state = S_UP0;
                end else begin
                    h_we     = 1'b1;
                    p_we     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DN0: begin
                h_raddr = c_idx[SW-1:0];
                if (!c_in) begin
                    h_we     = 1'b1;
                    p_we     = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DN1;
                end
            end
            S_DN1: begin
                h_raddr = rc_idx[SW-1:0];
                n_best  = h_rdata;
                n_bidx  = c_idx[SW-1:0];
                n_state = rc_in ? S_DN2 : S_DN3;
            end
            S_DN2: begin
                if (gt) begin
                    n_best = h_rdata;
                    n_bidx = rc_idx[SW-1:0];
                end
                n_state = S_DN3;
            end
            S_DN3: begin
                h_we = 1'b1;
                p_we = 1'b1;
                if (gt) begin
                    h_wdata = r_best;
                    p_waddr = r_best[VW-1:0];
                    n_p     = r_bidx;
                    n_state = S_DN0;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_size   <= '0;
            r_strobe <= 1'b0;
            r_clr    <= '0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_strobe <= n_strobe;
            r_clr    <= n_clr;
        end
        r_kind   <= n_kind;
        r_vtx    <= n_vtx;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_p      <= n_p;
        r_bidx   <= n_bidx;
        r_best   <= n_best;
        r_status <= n_status;
        r_ovtx   <= n_ovtx;
        r_okey   <= n_okey;
    end

    logic signed [KW-1:0] okey_s;
    logic signed [63:0]   okey_x;

    assign okey_s = r_okey;
    assign okey_x = 64'(okey_s);

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_vertex  = r_ovtx;
    assign o_rsp.out_key     = okey_x[31:0];
    assign o_rsp.is_empty    = (r_size == '0);
    assign o_rsp.entry_count = 11'(r_size);

    `HMDK_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy)
    `HMDK_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    `HMDK_ASSERT_IMP(a_size_cap, i_clk, i_rst_n, 1'b1, r_size <= SZW'(CAPACITY))
    `HMDK_ASSERT_IMP(a_empty_cnt, i_clk, i_rst_n, o_strobe, o_rsp.is_empty == (r_size == '0))

endmodule
`default_nettype wire

// File: design/hmdk_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the heap slots and the vertex position map; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hmdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/hmdk_keycmp.sv
// Shared signed key comparator used by the compare steps of the sequencer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module hmdk_keycmp #(
    parameter int KEY_WIDTH = 32
) (
    input  wire logic [KEY_WIDTH-1:0] i_a,
    input  wire logic [KEY_WIDTH-1:0] i_b,
    output logic                      o_gt
);

    assign o_gt = $signed(i_a) > $signed(i_b);

endmodule
`default_nettype wire

// File: tb/indexed_min_heap_decrease_key_top_tb.sv
// Testbench for the indexed min-heap: drives insert, decrease-key, extract, read, clear and
// unused command kinds and checks every response beat against an in-bench heap predictor.
// Depends on hmdk_pkg and indexed_min_heap_decrease_key_top.
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_top_tb;
    import hmdk_pkg::*;

    localparam int CAP = 1024;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_cmd i_cmd = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    indexed_min_heap_decrease_key_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_cmd(i_cmd),
        .busy(busy), .o_strobe(o_strobe), .o_rsp(o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic signed [31:0] hk [CAP];
    logic [9:0] hv [CAP];
    int unsigned vpos [1024];
    bit vpres [1024];
    int unsigned hsize;

    t_cmd pending_cmds[$];
    t_rsp expected_rsps[$];
    int mismatches = 0;
    int unexpected = 0;
    bit stim_done = 0;
    bit quiet_tail = 0;
    int idle_left = 0;
    int watchdog = 0;

    function automatic void add_cmd(t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic signed [31:0] tk;
        logic [9:0] tv;
        tk = hk[a]; tv = hv[a];
        hk[a] = hk[b]; hv[a] = hv[b];
        hk[b] = tk; hv[b] = tv;
        vpos[hv[a]] = a;
        vpos[hv[b]] = b;
    endfunction

    function automatic void sift_up(int unsigned p);
        int unsigned up;
        while (p > 0) begin
            up = (p - 1) / 2;
            if (!(hk[up] > hk[p])) break;
            swap_slots(p, up);
            p = up;
        end
    endfunction

    function automatic void sift_down(int unsigned p);
        int unsigned c;
        forever begin
            c = 2 * p + 1;
            if (c >= hsize) break;
            if (c + 1 < hsize && hk[c] > hk[c + 1]) c++;
            if (!(hk[p] > hk[c])) break;
            swap_slots(p, c);
            p = c;
        end
    endfunction

    function automatic t_rsp heap_apply(t_cmd c);
        t_rsp r;
        int unsigned p;
        r = '0;
        r.status = ST_OK;
        r.out_vertex = c.vertex;
        case (c.kind)
            K_INSERT: begin
                if (vpres[c.vertex]) r.status = ST_PRESENT;
                else if (hsize >= CAP) r.status = ST_FULL;
                else begin
                    p = hsize++;
                    hk[p] = c.key; hv[p] = c.vertex;
                    vpos[c.vertex] = p; vpres[c.vertex] = 1;
                    sift_up(p);
                end
            end
            K_DECREASE: begin
                if (!vpres[c.vertex]) r.status = ST_ABSENT;
                else begin
                    p = vpos[c.vertex];
                    if (p >= hsize || !(hk[p] > c.key)) r.status = ST_NOT_SMALLER;
                    else begin
                        hk[p] = c.key;
                        sift_up(p);
                    end
                end
            end
            K_EXTRACT: begin
                if (hsize == 0) begin
                    r.status = ST_EMPTY;
                    r.out_vertex = '0;
                end else begin
                    r.out_vertex = hv[0];
                    r.out_key = hk[0];
                    swap_slots(0, hsize - 1);
                    vpres[r.out_vertex] = 0;
                    hsize--;
                    sift_down(0);
                end
            end
            K_READ: begin
                if (!vpres[c.vertex] || vpos[c.vertex] >= hsize) r.status = ST_ABSENT;
                else r.out_key = hk[vpos[c.vertex]];
            end
            K_CLEAR: begin
                foreach (vpres[i]) vpres[i] = 0;
                hsize = 0;
            end
            default: ;
        endcase
        r.is_empty = (hsize == 0);
        r.entry_count = hsize[10:0];
        return r;
    endfunction

    function automatic t_cmd make_cmd(logic [2:0] k, int v, logic signed [31:0] key);
        t_cmd c;
        c.kind = k;
        c.vertex = v[9:0];
        c.key = key;
        return c;
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000 + $urandom_range(0, 3);
            1: return 32'sh7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Vertex ids come from a narrow pool most of the time so that hits, duplicates
    // and decrease-key on present vertices are frequent.
    function automatic int rand_vertex();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, 63);
        return $urandom_range(0, 1023);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_rsps.insert(expected_rsps.size(), heap_apply(i_cmd));
            end
            if ((start && !busy) || o_strobe) begin
                watchdog <= 0;
            end else begin
                watchdog <= watchdog + 1;
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                    start <= 1'b0;
                end else if (!quiet_tail && pending_cmds.size() > 0
                             && $urandom_range(0, 9) == 0) begin
                    idle_left <= $urandom_range(0, 6);
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    i_cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_strobe) begin
            if (expected_rsps.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10) $display("Response beat with none expected: %p", o_rsp);
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (o_rsp !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", exp_rsp, o_rsp);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && watchdog > WATCHDOG_LIMIT) begin
            $display("indexed_min_heap_decrease_key_top test failed");
            $finish;
        end
    end

    initial begin
        int n;
        int v;
        hsize = 0;
        foreach (vpres[i]) vpres[i] = 0;
        add_cmd(make_cmd(K_EXTRACT, 5, 0));
        add_cmd(make_cmd(K_READ, 1023, 0));
        add_cmd(make_cmd(K_DECREASE, 0, 0));
        add_cmd(make_cmd(K_INSERT, 0, 32'sh7fff_ffff));
        add_cmd(make_cmd(K_INSERT, 1023, 32'sh8000_0000));
        add_cmd(make_cmd(K_INSERT, 512, 7));
        add_cmd(make_cmd(K_INSERT, 341, 7));
        add_cmd(make_cmd(K_INSERT, 0, 1));
        add_cmd(make_cmd(K_DECREASE, 512, 7));
        add_cmd(make_cmd(K_DECREASE, 512, 9));
        add_cmd(make_cmd(K_DECREASE, 0, -5));
        add_cmd(make_cmd(K_READ, 0, 0));
        add_cmd(make_cmd(K_READ, 1023, 0));
        add_cmd(make_cmd(3'd5, 682, 32'sh5555_5555));
        add_cmd(make_cmd(3'd6, 1, -1));
        add_cmd(make_cmd(3'd7, 2, 0));
        for (int i = 0; i < 4; i++) add_cmd(make_cmd(K_EXTRACT, 0, 0));
        add_cmd(make_cmd(K_INSERT, 9, 3));
        add_cmd(make_cmd(K_CLEAR, 777, 32'sh1234_5678));
        add_cmd(make_cmd(K_READ, 9, 0));
        add_cmd(make_cmd(K_EXTRACT, 0, 0));

        // Fill to capacity once, re-insert a vertex that is present, then clear the heap.
        for (int i = 0; i < CAP; i++) add_cmd(make_cmd(K_INSERT, i, rand_key()));
        add_cmd(make_cmd(K_INSERT, 5, 0));
        add_cmd(make_cmd(K_CLEAR, 0, 0));
        add_cmd(make_cmd(K_INSERT, 5, 0));
        add_cmd(make_cmd(K_CLEAR, 0, 0));

        n = 0;
        while (n < 950) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: add_cmd(
                    make_cmd(K_INSERT, rand_vertex(), rand_key()));
                6, 7, 8, 9: add_cmd(
                    make_cmd(K_DECREASE, rand_vertex(), rand_key()));
                10, 11, 12, 13, 14: add_cmd(
                    make_cmd(K_EXTRACT, $urandom_range(0, 1023), $urandom));
                15, 16, 17: add_cmd(
                    make_cmd(K_READ, rand_vertex(), $urandom));
                18: add_cmd(make_cmd(
                    ($urandom_range(0, 7) == 0) ? K_CLEAR : 3'($urandom_range(5, 7)),
                    $urandom_range(0, 1023), $urandom));
                default: begin
                    v = rand_vertex();
                    add_cmd(make_cmd(K_INSERT, v, $urandom));
                    add_cmd(make_cmd(K_DECREASE, v, rand_key()));
                    n++;
                end
            endcase
            n++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() < 300);
        quiet_tail = 1;
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_rsps.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("indexed_min_heap_decrease_key_top test passed");
        else
            $display("indexed_min_heap_decrease_key_top test failed");
        $finish;
    end
endmodule
